@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Width of the tick and poll counters; register values are truncated to it.
  localparam int CNT_W = 16;
  localparam int CFG_W = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_DELAY = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] HALF_PERIOD_RST  = 16'd16;
  localparam logic [CFG_W-1:0] SAMPLE_DELAY_RST = 16'd8;
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST  = 16'd250;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_WAIT_ACK = 3'd4
  } i2cm_cmd_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_drive;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } i2cm_out_t;

  // Counter load value; a zero tick count behaves as one.
  function automatic logic [CNT_W-1:0] load_ticks(input logic [CFG_W-1:0] ticks);
    logic [CNT_W-1:0] c;
    c = CNT_W'(ticks);
    if (c == '0) begin
      c = CNT_W'(1);
    end
    return c;
  endfunction

endpackage

@@ rtl/i2c_master_bit_engine_unit.sv @@
// The result of an accepted request (one bus tick) is registered and shows in the next cycle.
// Throughput: one request per clock; the output register is the only stage,
// and a request is taken whenever that register is empty or being drained.
// Reset (rst_n low, synchronous): bus idle high, engine idle, config
// registers back to 16 / 8 / 250 ticks, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine. Each request is one tick: it may carry a command
// (start, stop, write byte, read byte, wait ack) and always carries the
// sampled SDA level. The engine steps its phase machine once per request and
// returns the bus drive levels and status for that tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit
  import i2cm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration write port
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // tick requests
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cm_in_t         in_data,
  // per-tick results
  output logic             out_valid,
  input  logic             out_stall,
  output i2cm_out_t        out_data
);

  // Drive phases of the bus sequencer
  typedef enum logic [3:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_FS1, PH_FS2,
    PH_WB_LOW, PH_WB_HIGH, PH_WB_TAIL, PH_RB_LOW, PH_RB_HIGH,
    PH_AK_LOW, PH_AK_HIGH, PH_WA_DELAY, PH_WA_POLL
  } phase_t;

  // Config registers
  logic [CFG_W-1:0] half_r, sample_r, timeout_r;

  // Engine state
  phase_t           phase_r,  phase_nxt;
  logic [3:0]       bit_r,    bit_nxt;
  logic [7:0]       shift_r,  shift_nxt;
  logic [CNT_W-1:0] delay_r,  delay_nxt;
  logic [CNT_W-1:0] poll_r,   poll_nxt;
  logic [7:0]       rx_r,     rx_nxt;
  logic             scl_r,    scl_nxt;
  logic             sda_r,    sda_nxt;
  logic             oe_r,     oe_nxt;
  logic             fail_r,   fail_nxt;
  logic             ackm_r,   ackm_nxt;
  logic             done_nxt;

  // Result register
  logic             out_valid_r;
  i2cm_out_t        out_data_r, out_data_nxt;

  logic             in_acc;
  logic [3:0]       bit_inc;
  logic [7:0]       shift_sl;

  // A request is taken whenever the result register is free or being taken.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign bit_inc  = bit_r + 4'd1;
  assign shift_sl = {shift_r[6:0], 1'b0};

  // Next-state logic for one tick
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    delay_nxt = delay_r;
    poll_nxt  = poll_r;
    rx_nxt    = rx_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    oe_nxt    = oe_r;
    fail_nxt  = fail_r;
    ackm_nxt  = ackm_r;
    done_nxt  = 1'b0;

    if (phase_r == PH_IDLE) begin
      // New command; unknown codes leave the engine idle.
      if (in_data.cmd_valid) begin
        unique case (i2cm_cmd_t'(in_data.command))
          CMD_START: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            oe_nxt    = 1'b1;
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_ST1;
          end
          CMD_STOP: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            oe_nxt    = 1'b1;
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_SP1;
          end
          CMD_WRITE: begin
            shift_nxt = in_data.tx_byte;
            bit_nxt   = '0;
            scl_nxt   = 1'b0;
            oe_nxt    = 1'b1;
            sda_nxt   = in_data.tx_byte[7];
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_WB_LOW;
          end
          CMD_READ: begin
            shift_nxt = '0;
            bit_nxt   = '0;
            ackm_nxt  = in_data.ack_after_read;
            scl_nxt   = 1'b0;
            oe_nxt    = 1'b0;
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_RB_LOW;
          end
          CMD_WAIT_ACK: begin
            oe_nxt    = 1'b0;
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
            delay_nxt = load_ticks(sample_r);
            phase_nxt = PH_WA_DELAY;
          end
          default: ;
        endcase
      end
    end else if (phase_r == PH_WA_POLL) begin
      if (!in_data.sda_in) begin
        // slave acknowledged
        oe_nxt    = 1'b1;
        scl_nxt   = 1'b0;
        fail_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        done_nxt  = 1'b1;
      end else if (poll_r >= CNT_W'(timeout_r)) begin
        // timeout: run the stop sequence, flag failure at its end
        oe_nxt    = 1'b1;
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        delay_nxt = load_ticks(half_r);
        phase_nxt = PH_FS1;
      end else begin
        poll_nxt = poll_r + CNT_W'(1);
      end
    end else if (delay_r > CNT_W'(1)) begin
      delay_nxt = delay_r - CNT_W'(1);
    end else begin
      delay_nxt = '0;
      unique case (phase_r)
        PH_ST1: begin
          sda_nxt   = 1'b0;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_ST2;
        end
        PH_ST2: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_SP1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_SP2;
        end
        PH_FS1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_FS2;
        end
        PH_FS2: begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_WB_LOW: begin
          scl_nxt   = 1'b1;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_WB_HIGH;
        end
        PH_WB_HIGH: begin
          scl_nxt   = 1'b0;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_WB_TAIL;
        end
        PH_WB_TAIL: begin
          bit_nxt   = bit_inc;
          shift_nxt = shift_sl;
          if (bit_inc >= 4'd8) begin
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            sda_nxt   = shift_sl[7];
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_WB_LOW;
          end
        end
        PH_RB_LOW: begin
          // SCL rises; sample SDA on this tick
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], in_data.sda_in};
          delay_nxt = load_ticks(sample_r);
          phase_nxt = PH_RB_HIGH;
        end
        PH_RB_HIGH: begin
          bit_nxt = bit_inc;
          scl_nxt = 1'b0;
          if (bit_inc >= 4'd8) begin
            rx_nxt    = shift_r;
            oe_nxt    = 1'b1;
            sda_nxt   = ~ackm_r;
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_AK_LOW;
          end else begin
            delay_nxt = load_ticks(half_r);
            phase_nxt = PH_RB_LOW;
          end
        end
        PH_AK_LOW: begin
          scl_nxt   = 1'b1;
          delay_nxt = load_ticks(half_r);
          phase_nxt = PH_AK_HIGH;
        end
        PH_AK_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_WA_DELAY: begin
          poll_nxt  = '0;
          phase_nxt = PH_WA_POLL;
        end
        default: begin
          // end of stop sequence
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      endcase
    end

    out_data_nxt.scl_out    = scl_nxt;
    out_data_nxt.sda_drive  = sda_nxt;
    out_data_nxt.sda_oe     = oe_nxt;
    out_data_nxt.busy_res   = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res   = done_nxt;
    out_data_nxt.rx_byte    = rx_nxt;
    out_data_nxt.ack_failed = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_PERIOD_RST;
      sample_r    <= SAMPLE_DELAY_RST;
      timeout_r   <= ACK_TIMEOUT_RST;
      phase_r     <= PH_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      delay_r     <= '0;
      poll_r      <= '0;
      rx_r        <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      oe_r        <= 1'b1;
      fail_r      <= 1'b0;
      ackm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALF_PERIOD:  half_r    <= cfg_wdata;
          CFG_SAMPLE_DELAY: sample_r  <= cfg_wdata;
          CFG_ACK_TIMEOUT:  timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        bit_r       <= bit_nxt;
        shift_r     <= shift_nxt;
        delay_r     <= delay_nxt;
        poll_r      <= poll_nxt;
        rx_r        <= rx_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        oe_r        <= oe_nxt;
        fail_r      <= fail_nxt;
        ackm_r      <= ackm_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted tick
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input i2cm_out_t        out_data
);

  // every accepted tick yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // input side only backs up when a result is waiting and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (.*);

@@ tb/i2c_master_bit_engine_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit_test
// Self-checking bench for the I2C master bit engine. Tick requests are
// queued by a stimulus process, sent by a clocked driver under random
// sender gaps, and each accepted request is run through a bench-side
// engine model. A clocked monitor stalls at random and checks every result
// field against the oldest predicted bus state.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_test;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_TICKS    = 60;
  localparam int MAX_REPORTS    = 100;

  // Bench-side phases of the engine. Only the model uses these.
  typedef enum logic [4:0] {
    ENG_IDLE,
    ENG_START_HOLD,   // SDA and SCL high
    ENG_START_LOW,    // SDA low, SCL still high
    ENG_STOP_LOW,     // both low
    ENG_STOP_HIGH,    // both released high
    ENG_ABORT_LOW,    // stop after a missing ack
    ENG_ABORT_HIGH,
    ENG_WR_LOW,
    ENG_WR_HIGH,
    ENG_WR_TAIL,
    ENG_RD_LOW,
    ENG_RD_HIGH,
    ENG_ACK_LOW,
    ENG_ACK_HIGH,
    ENG_WAIT_SETTLE,  // SCL high, before the first poll
    ENG_WAIT_POLL
  } eng_phase_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = CFG_HALF_PERIOD;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  i2cm_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  i2cm_out_t        out_data;

  i2c_master_bit_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus state
  i2cm_in_t  tick_req_q[$];          // requests not yet offered
  i2cm_out_t expected_levels_q[$];   // predicted results, oldest first
  int        send_gap_pct = 0;
  int        stall_pct    = 0;
  int        stim_ticks;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;

  // Timing settings for the random phases: half period, sample delay, timeout.
  // Zeros check that a zero count behaves as one and that a zero timeout
  // gives up on the first high poll.
  int half_tab[6] = '{1, 0, 2, 3, 1, 2};
  int samp_tab[6] = '{1, 0, 3, 2, 4, 1};
  int tmo_tab[6]  = '{1, 0, 4, 12, 2, 7};

  // --------------------------------------------------------------------------
  // Engine model: configuration copy and engine state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_half, cfg_sample, cfg_timeout;
  eng_phase_t       eng;
  logic [3:0]       bit_cnt;
  logic [7:0]       shifter;
  logic [CNT_W-1:0] tick_cnt;
  logic [CNT_W-1:0] poll_cnt;
  logic [7:0]       rx_q;
  logic             scl_q, sda_q, oe_q, fail_q, ack_q;

  function automatic void reset_model();
    cfg_half    = HALF_PERIOD_RST;
    cfg_sample  = SAMPLE_DELAY_RST;
    cfg_timeout = ACK_TIMEOUT_RST;
    eng      = ENG_IDLE;
    bit_cnt  = '0;
    shifter  = '0;
    tick_cnt = '0;
    poll_cnt = '0;
    rx_q     = '0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
    oe_q     = 1'b1;
    fail_q   = 1'b0;
    ack_q    = 1'b0;
  endfunction

  // Enter a phase that lasts the given number of ticks (zero counts as one).
  function automatic void load_phase(eng_phase_t nxt, logic [CFG_W-1:0] ticks);
    tick_cnt = CNT_W'(ticks);
    if (tick_cnt == '0) begin
      tick_cnt = CNT_W'(1);
    end
    eng = nxt;
  endfunction

  // One bus tick: returns drive levels and status after the tick.
  function automatic i2cm_out_t predict_bus_tick(i2cm_in_t req);
    i2cm_out_t res;
    logic      done;
    done = 1'b0;
    if (eng == ENG_IDLE) begin
      if (req.cmd_valid) begin
        case (req.command)
          CMD_START: begin
            scl_q = 1'b1; sda_q = 1'b1; oe_q = 1'b1;
            load_phase(ENG_START_HOLD, cfg_half);
          end
          CMD_STOP: begin
            scl_q = 1'b0; sda_q = 1'b0; oe_q = 1'b1;
            load_phase(ENG_STOP_LOW, cfg_half);
          end
          CMD_WRITE: begin
            shifter = req.tx_byte;
            bit_cnt = '0;
            scl_q = 1'b0; oe_q = 1'b1;
            sda_q = req.tx_byte[7];
            load_phase(ENG_WR_LOW, cfg_half);
          end
          CMD_READ: begin
            shifter = '0;
            bit_cnt = '0;
            ack_q = req.ack_after_read;
            scl_q = 1'b0; oe_q = 1'b0;
            load_phase(ENG_RD_LOW, cfg_half);
          end
          CMD_WAIT_ACK: begin
            oe_q = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
            load_phase(ENG_WAIT_SETTLE, cfg_sample);
          end
          default: ;  // codes above wait-ack leave the engine idle
        endcase
      end
    end else if (eng == ENG_WAIT_POLL) begin
      if (!req.sda_in) begin
        oe_q = 1'b1; scl_q = 1'b0; fail_q = 1'b0;
        eng  = ENG_IDLE;
        done = 1'b1;
      end else if (poll_cnt >= CNT_W'(cfg_timeout)) begin
        // no ack: take the bus back and run a stop
        oe_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
        load_phase(ENG_ABORT_LOW, cfg_half);
      end else begin
        poll_cnt = poll_cnt + CNT_W'(1);
      end
    end else if (tick_cnt > CNT_W'(1)) begin
      tick_cnt = tick_cnt - CNT_W'(1);
    end else begin
      tick_cnt = '0;
      case (eng)
        ENG_START_HOLD: begin
          sda_q = 1'b0;
          load_phase(ENG_START_LOW, cfg_half);
        end
        ENG_START_LOW: begin
          scl_q = 1'b0;
          eng = ENG_IDLE; done = 1'b1;
        end
        ENG_STOP_LOW, ENG_ABORT_LOW: begin
          scl_q = 1'b1; sda_q = 1'b1;
          load_phase((eng == ENG_STOP_LOW) ? ENG_STOP_HIGH : ENG_ABORT_HIGH, cfg_half);
        end
        ENG_ABORT_HIGH: begin
          fail_q = 1'b1;
          eng = ENG_IDLE; done = 1'b1;
        end
        ENG_WR_LOW: begin
          scl_q = 1'b1;
          load_phase(ENG_WR_HIGH, cfg_half);
        end
        ENG_WR_HIGH: begin
          scl_q = 1'b0;
          load_phase(ENG_WR_TAIL, cfg_half);
        end
        ENG_WR_TAIL: begin
          bit_cnt = bit_cnt + 4'd1;
          shifter = shifter << 1;
          if (bit_cnt >= 4'd8) begin
            eng = ENG_IDLE; done = 1'b1;
          end else begin
            sda_q = shifter[7];
            load_phase(ENG_WR_LOW, cfg_half);
          end
        end
        ENG_RD_LOW: begin
          scl_q = 1'b1;
          shifter = {shifter[6:0], req.sda_in};
          load_phase(ENG_RD_HIGH, cfg_sample);
        end
        ENG_RD_HIGH: begin
          bit_cnt = bit_cnt + 4'd1;
          scl_q = 1'b0;
          if (bit_cnt >= 4'd8) begin
            rx_q  = shifter;
            oe_q  = 1'b1;
            sda_q = ~ack_q;  // low for ACK
            load_phase(ENG_ACK_LOW, cfg_half);
          end else begin
            load_phase(ENG_RD_LOW, cfg_half);
          end
        end
        ENG_ACK_LOW: begin
          scl_q = 1'b1;
          load_phase(ENG_ACK_HIGH, cfg_half);
        end
        ENG_ACK_HIGH: begin
          scl_q = 1'b0;
          eng = ENG_IDLE; done = 1'b1;
        end
        ENG_WAIT_SETTLE: begin
          poll_cnt = '0;
          eng = ENG_WAIT_POLL;
        end
        default: begin  // end of a stop
          eng = ENG_IDLE; done = 1'b1;
        end
      endcase
    end
    res.scl_out    = scl_q;
    res.sda_drive  = sda_q;
    res.sda_oe     = oe_q;
    res.busy_res   = (eng != ENG_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_q;
    res.ack_failed = fail_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_levels_q.push_back(predict_bus_tick(in_data));
      end
      // a stalled request stays put; otherwise pick the next or go idle
      if (!in_valid || !in_stall) begin
        if (tick_req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= tick_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall, field-by-field check against the oldest prediction
  // --------------------------------------------------------------------------
  i2cm_out_t want_levels;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels_q.size() == 0) begin
          report_mismatch("result with no request pending", '0, '0);
        end else begin
          want_levels = expected_levels_q.pop_front();
          if (out_data.scl_out !== want_levels.scl_out)
            report_mismatch("scl_out", 8'(out_data.scl_out), 8'(want_levels.scl_out));
          if (out_data.sda_drive !== want_levels.sda_drive)
            report_mismatch("sda_drive", 8'(out_data.sda_drive),
                            8'(want_levels.sda_drive));
          if (out_data.sda_oe !== want_levels.sda_oe)
            report_mismatch("sda_oe", 8'(out_data.sda_oe), 8'(want_levels.sda_oe));
          if (out_data.busy_res !== want_levels.busy_res)
            report_mismatch("busy_res", 8'(out_data.busy_res), 8'(want_levels.busy_res));
          if (out_data.done_res !== want_levels.done_res)
            report_mismatch("done_res", 8'(out_data.done_res), 8'(want_levels.done_res));
          if (out_data.rx_byte !== want_levels.rx_byte)
            report_mismatch("rx_byte", out_data.rx_byte, want_levels.rx_byte);
          if (out_data.ack_failed !== want_levels.ack_failed)
            report_mismatch("ack_failed", 8'(out_data.ack_failed),
                            8'(want_levels.ack_failed));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_tick(bit valid, logic [2:0] code, logic [7:0] tx, bit ack, bit sda);
    i2cm_in_t r;
    r.cmd_valid      = valid;
    r.command        = code;
    r.tx_byte        = tx;
    r.ack_after_read = ack;
    r.sda_in         = sda;
    tick_req_q.push_back(r);
  endtask

  // Ticks while a command runs. Stray commands are mixed in; the engine must
  // ignore them, including on the tick that finishes the command.
  task automatic busy_ticks(int n, bit fixed_sda, bit level);
    repeat (n) begin
      push_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 8'($urandom),
                1'($urandom), fixed_sda ? level : 1'($urandom));
      stim_ticks++;
    end
  endtask

  // Idle ticks: nothing valid, or codes the engine does not know.
  task automatic gap(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        push_tick(1'b1, 3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        push_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // Offer one command and pad for exactly as long as it runs, so the next
  // command lands on the first idle tick. For wait-ack, ack_poll selects the
  // poll that sees SDA low; zero holds SDA high until the engine gives up.
  task automatic run_command(i2cm_cmd_t code, logic [7:0] tx, bit ack, int ack_poll);
    int h, s, t;
    h = (cfg_half == 0) ? 1 : int'(cfg_half);
    s = (cfg_sample == 0) ? 1 : int'(cfg_sample);
    t = int'(cfg_timeout);
    push_tick(1'b1, code, tx, ack, 1'($urandom));
    stim_ticks++;
    case (code)
      CMD_START, CMD_STOP: busy_ticks(2 * h, 1'b0, 1'b0);
      CMD_WRITE:           busy_ticks(24 * h, 1'b0, 1'b0);
      CMD_READ:            busy_ticks(8 * (h + s) + 2 * h, 1'b0, 1'b0);
      CMD_WAIT_ACK: begin
        busy_ticks(s, 1'b0, 1'b0);
        if (ack_poll > 0) begin
          busy_ticks(ack_poll - 1, 1'b1, 1'b1);
          busy_ticks(1, 1'b1, 1'b0);
        end else begin
          busy_ticks(t + 1, 1'b1, 1'b1);
          busy_ticks(2 * h, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_ack_poll();
    int top;
    top = (int'(cfg_timeout) + 1 < 8) ? int'(cfg_timeout) + 1 : 8;
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, top);
  endfunction

  // A well-formed transfer: start, address, ack, a few bytes, stop.
  task automatic transfer();
    int nbytes, ap;
    bit reading;
    run_command(CMD_START, 8'($urandom), 1'($urandom), 0);
    gap($urandom_range(0, 3));
    run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
    gap($urandom_range(0, 3));
    ap = pick_ack_poll();
    run_command(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), ap);
    if (ap == 0) begin
      return;  // engine already stopped the bus
    end
    nbytes  = $urandom_range(1, 3);
    reading = 1'($urandom);
    for (int i = 0; i < nbytes; i++) begin
      gap($urandom_range(0, 3));
      if (reading) begin
        run_command(CMD_READ, 8'($urandom), (i != nbytes - 1), 0);
      end else begin
        run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
        ap = pick_ack_poll();
        run_command(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), ap);
        if (ap == 0) begin
          return;
        end
      end
    end
    gap($urandom_range(0, 3));
    run_command(CMD_STOP, 8'($urandom), 1'($urandom), 0);
  endtask

  // Commands in any order, then raw random ticks and a long idle stretch so
  // the engine is quiet again before the phase ends.
  task automatic scramble();
    int h, s;
    h = (cfg_half == 0) ? 1 : int'(cfg_half);
    s = (cfg_sample == 0) ? 1 : int'(cfg_sample);
    repeat ($urandom_range(1, 4)) begin
      run_command(i2cm_cmd_t'($urandom_range(0, 4)), 8'($urandom), 1'($urandom),
                  pick_ack_poll());
      gap($urandom_range(0, 2));
    end
    repeat ($urandom_range(5, 30)) begin
      push_tick(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      stim_ticks++;
    end
    repeat (34 * h + 9 * s + int'(cfg_timeout) + 8) begin
      push_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Wait until every request is sent and every result checked.
  task automatic drain();
    do @(negedge clk);
    while (tick_req_q.size() != 0 || in_valid || expected_levels_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register writes, only while nothing is in flight.
  task automatic set_timing(int h, int s, int t);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_HALF_PERIOD;  cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_DELAY; cfg_wdata <= CFG_W'(s);
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;  cfg_wdata <= CFG_W'(t);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_half    = CFG_W'(h);
    cfg_sample  = CFG_W'(s);
    cfg_timeout = CFG_W'(t);
  endtask

  // 0: no gaps, 1: sender mostly idle, 2: receiver mostly stalled, 3: both.
  function automatic void set_pacing(int mode);
    send_gap_pct = (mode == 1) ? 72 : (mode == 3) ? 33 : 0;
    stall_pct    = (mode == 2) ? 72 : (mode == 3) ? 33 : 0;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset timing (16 / 8 / 250): unknown codes and a
    // dropped valid while idle, a write with both bit levels, an ack on the
    // first poll, a read with ACK, and a missing ack.
    set_pacing(0);
    push_tick(1'b1, 3'd5, 8'h00, 1'b0, 1'b0);
    push_tick(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1);
    push_tick(1'b1, 3'd7, 8'h00, 1'b0, 1'b0);
    push_tick(1'b0, CMD_START, 8'hFF, 1'b1, 1'b1);
    run_command(CMD_START, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'hA5, 1'b0, 0);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 1);
    run_command(CMD_READ, 8'h5A, 1'b1, 0);
    run_command(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    run_command(CMD_STOP, 8'hFF, 1'b1, 0);
    drain();

    // Random phases across timing settings and pacing modes.
    for (int p = 0; p < 6; p++) begin
      set_timing(half_tab[p], samp_tab[p], tmo_tab[p]);
      set_pacing(p % 4);
      stim_ticks = 0;
      while (stim_ticks < PHASE_TICKS) begin
        if ($urandom_range(0, 9) < 8) begin
          transfer();
        end else begin
          scramble();
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/i2cm_pkg.sv
rtl/i2c_master_bit_engine_unit.sv
rtl/i2cm_checker.sv
tb/i2c_master_bit_engine_unit_test.sv
